[hdl/hfla_pkg.sv]
// ----------------------------------------------------------------------------
// hfla_pkg
// Shared types and constants for the handle free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hfla_pkg;

	// Default number of slots and the hard limit set by the 8-bit handle
	localparam int unsigned SLOT_COUNT_DEF = 256;
	localparam int unsigned HANDLE_LIMIT   = 256;

	// Field widths
	localparam int unsigned HANDLE_W = 8;
	localparam int unsigned LINK_W   = 9;
	localparam int unsigned STATUS_W = 2;

	// Request codes
	typedef enum logic {
		ACT_ALLOCATE = 1'b0,
		ACT_RELEASE  = 1'b1
	} action_t;

	// Response codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_FULL         = 2'd1,
		ST_INVALID      = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	// One word of the link store
	typedef struct packed {
		logic              used;
		logic [LINK_W-1:0] link;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
		logic cfg_write;
	} hfla_cmd_t;

endpackage : hfla_pkg

`default_nettype wire

[hdl/hfla_if.sv]
// ----------------------------------------------------------------------------
// hfla_if
// Valid/ready channels: request, response and capacity configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfla_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] slot_handle;

	modport source (output valid, output action, output slot_handle, input ready);
	modport sink   (input valid, input action, input slot_handle, output ready);
endinterface : hfla_req_if

interface hfla_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] granted_handle;

	modport source (output valid, output status, output granted_handle, input ready);
	modport sink   (input valid, input status, input granted_handle, output ready);
endinterface : hfla_rsp_if

interface hfla_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] capacity_in_use;

	modport source (output valid, output capacity_in_use, input ready);
	modport sink   (input valid, input capacity_in_use, output ready);
endinterface : hfla_cfg_if

`default_nettype wire

[hdl/handle_free_list_allocator_unit.sv]
// ----------------------------------------------------------------------------
// handle_free_list_allocator_unit
// Slot handle allocator over a linked free list held in a link store.
// ----------------------------------------------------------------------------
// Usage:
//   req : action 0 allocates the head slot, action 1 releases slot_handle.
//   rsp : one response per request, status 0 ok, 1 full, 2 invalid handle,
//         3 already free; granted_handle carries the slot on ok, else 0.
//   cfg : writes capacity_in_use and rebuilds the free list at once; write
//         only while no request is outstanding.
// Timing: a request is taken only when idle, the link store is read with a
//   registered port on accept and the response is registered on commit, so
//   a new request waits until the last one has committed. The read of the
//   head's link must complete before the next pop.
// Reset: capacity 256, head 0, every slot free; per-entry valid bits are
//   cleared at once, so no clearing pass is needed.
// Stall: a request can be taken while a response waits; its commit then
//   holds in the lookup state until the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_free_list_allocator_unit
	import hfla_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hfla_req_if.sink    req,
	hfla_rsp_if.source  rsp,
	hfla_cfg_if.sink    cfg
);

	hfla_cmd_t cmd;

	// Sequence requests and drive the handshakes
	hfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cmd       (cmd)
	);

	// Link store, head and response register
	hfla_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_action   (req.action),
		.req_handle   (req.slot_handle),
		.cfg_capacity (cfg.capacity_in_use),
		.rsp_status   (rsp.status),
		.rsp_handle   (rsp.granted_handle)
	);

endmodule : handle_free_list_allocator_unit

`default_nettype wire

[hdl/hfla_ctrl.sv]
// ----------------------------------------------------------------------------
// hfla_ctrl
// Controller: sequences one request through lookup and commit, owns the
// handshakes of all channels.
// ----------------------------------------------------------------------------
`default_nettype none

module hfla_ctrl
	import hfla_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	output hfla_cmd_t      cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	// Take a request only when idle; configuration is always taken
	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;

	// Issue commands; commit once the output register is free
	always_comb begin
		cmd.accept    = req_valid && req_ready;
		cmd.commit    = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
		cmd.cfg_write = cfg_valid;
	end

	// Hold state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// A taken request blocks the next one during its lookup
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !req_ready)
		else $error("request accepted twice in a row");

	// A commit always presents a response
	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("commit without response valid");
`endif

endmodule : hfla_ctrl

`default_nettype wire

[hdl/hfla_dp.sv]
// ----------------------------------------------------------------------------
// hfla_dp
// Datapath: link store memory with per-entry valid bits, free list head,
// capacity register and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module hfla_dp
	import hfla_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hfla_cmd_t             cmd,
	input  wire logic                  req_action,
	input  wire logic [HANDLE_W-1:0]   req_handle,
	input  wire logic [LINK_W-1:0]     cfg_capacity,
	output logic [STATUS_W-1:0]        rsp_status,
	output logic [HANDLE_W-1:0]        rsp_handle
);

	localparam int unsigned MEM_DEPTH =
		(SLOT_COUNT > HANDLE_LIMIT) ? HANDLE_LIMIT : SLOT_COUNT;
	localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam logic [LINK_W-1:0] CAP_LIMIT = LINK_W'(MEM_DEPTH);

	// Link store and its valid bits
	entry_t                 link_mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]   vld_q;

	logic [LINK_W-1:0]      cap_q;
	logic [LINK_W-1:0]      head_q;
	action_t                action_q;
	logic [HANDLE_W-1:0]    handle_q;
	logic [AW-1:0]          addr_q;
	entry_t                 rd_entry_q;
	logic                   rd_vld_q;
	status_t                status_q;
	logic [HANDLE_W-1:0]    granted_q;

	logic [AW-1:0]          rd_addr;
	logic [LINK_W-1:0]      cap_eff;
	logic [LINK_W-1:0]      link_rd;
	logic                   used_rd;
	status_t                status_d;
	logic [HANDLE_W-1:0]    granted_d;
	logic [LINK_W-1:0]      head_d;
	logic                   mem_we;
	entry_t                 wr_entry;

	// Select lookup address: released handle or current head
	assign rd_addr = (req_action == ACT_RELEASE) ? req_handle[AW-1:0] : head_q[AW-1:0];

	// Clamp capacity to the slots that exist
	assign cap_eff = (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q;

	// Entries never written read as their reset value
	assign link_rd = rd_vld_q ? rd_entry_q.link : (LINK_W'(addr_q) + LINK_W'(1));
	assign used_rd = rd_vld_q && rd_entry_q.used;

	// Decide the outcome of the pending request
	always_comb begin
		status_d      = ST_OK;
		granted_d     = '0;
		head_d        = head_q;
		mem_we        = 1'b0;
		wr_entry.used = 1'b0;
		wr_entry.link = link_rd;
		if (action_q == ACT_ALLOCATE) begin
			if (head_q >= cap_eff) begin
				status_d = ST_FULL;
			end else begin
				granted_d     = head_q[HANDLE_W-1:0];
				head_d        = link_rd;
				mem_we        = 1'b1;
				wr_entry.used = 1'b1;
			end
		end else begin
			if ({1'b0, handle_q} >= cap_eff) begin
				status_d = ST_INVALID;
			end else if (!used_rd) begin
				status_d = ST_ALREADY_FREE;
			end else begin
				granted_d     = handle_q;
				head_d        = {1'b0, handle_q};
				mem_we        = 1'b1;
				wr_entry.used = 1'b0;
				wr_entry.link = head_q;
			end
		end
	end

	// Read on accept, write on commit
	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we) begin
			link_mem[addr_q] <= wr_entry;
		end
		if (cmd.accept) begin
			rd_entry_q <= link_mem[rd_addr];
		end
	end

	// Latch the request and the response payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= action_t'(req_action);
			handle_q <= req_handle;
			addr_q   <= rd_addr;
			rd_vld_q <= vld_q[rd_addr];
		end
		if (cmd.commit) begin
			status_q  <= status_d;
			granted_q <= granted_d;
		end
	end

	// Hold capacity, head and valid bits; a capacity write rebuilds the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= LINK_W'(HANDLE_LIMIT);
			head_q <= '0;
			vld_q  <= '0;
		end else if (cmd.cfg_write) begin
			cap_q  <= cfg_capacity;
			head_q <= '0;
			vld_q  <= '0;
		end else if (cmd.commit && mem_we) begin
			head_q         <= head_d;
			vld_q[addr_q]  <= 1'b1;
		end
	end

	assign rsp_status = status_q;
	assign rsp_handle = granted_q;

`ifndef SYNTH
	// The head never points past the end-of-list marker
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= CAP_LIMIT)
		else $error("free list head out of range");

	// A granted allocation lies inside the capacity
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && status_d == ST_OK) |-> ({1'b0, granted_d} < cap_eff))
		else $error("granted handle beyond capacity");

	// A successful commit marks its entry as written
	a_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && mem_we && !cmd.cfg_write) |=> vld_q[$past(addr_q)])
		else $error("link entry not marked valid after write");
`endif

endmodule : hfla_dp

`default_nettype wire
